FILE: sv/i2cm_pkg.sv
// i2cm_pkg: shared types and codes for the I2C master byte engine.
// No dependencies; imported by i2c_master_byte_engine.
`default_nettype none

package i2cm_pkg;

   localparam int unsigned PeriodWidth = 16;
   localparam logic [PeriodWidth-1:0] PeriodReset = 16'd20;

   // command / operation codes
   localparam logic [2:0] OP_IDLE  = 3'd0;
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_STOP  = 3'd2;
   localparam logic [2:0] OP_WRITE = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;

   // phase steps within an operation
   localparam logic [2:0] PH0 = 3'd0;
   localparam logic [2:0] PH1 = 3'd1;
   localparam logic [2:0] PH2 = 3'd2;
   localparam logic [2:0] PH3 = 3'd3;
   localparam logic [2:0] PH4 = 3'd4;
   localparam logic [2:0] PH5 = 3'd5;
   localparam logic [2:0] PH6 = 3'd6;
   localparam logic [2:0] PH7 = 3'd7;

   // bit counter marks
   localparam logic [3:0] BIT_LAST     = 4'd7;
   localparam logic [3:0] BIT_ACK_WAIT = 4'd8;
   localparam logic [3:0] BIT_ACK_SEND = 4'd9;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] data_byte;
      logic       send_ack;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       ack_error;
   } rsp_type;

endpackage

`default_nettype wire

FILE: sv/i2c_master_byte_engine.sv
// i2c_master_byte_engine: bit-banged I2C master, one byte-level operation at a time.
// Depends on i2cm_pkg for payload types, command codes and phase codes.
//
//   channel | ports                          | direction | carries
//   req     | req_valid req_ready req_data   | in        | one tick, optional command
//   rsp     | rsp_valid rsp_ready rsp_data   | out       | bus levels and status per tick
//   csr     | csr_valid csr_ready csr_data   | in        | half_period_ticks
//
// Every req item yields exactly one rsp item, registered as the item is accepted.
// The bus state advances only on accepted items, so one item is one bus tick;
// with rsp_ready high an item is taken every cycle.
// A full output register with rsp_ready low holds req_ready low.
// Synchronous reset: idle, SCL and SDA high and driven, period 20.
`default_nettype none

module i2c_master_byte_engine #(
   parameter logic [i2cm_pkg::PeriodWidth-1:0] PERIOD_RESET = i2cm_pkg::PeriodReset
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_ready,
   input  wire i2cm_pkg::req_type                req_data,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   output      i2cm_pkg::rsp_type                rsp_data,
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic [i2cm_pkg::PeriodWidth-1:0] csr_data
);
   import i2cm_pkg::*;

   logic [PeriodWidth-1:0] period_ff;
   logic [2:0]             op_ff,    op_in;
   logic [2:0]             step_ff,  step_in;
   logic [3:0]             bit_ff,   bit_in;
   logic [PeriodWidth-1:0] dly_ff,   dly_in;
   logic [7:0]             shf_ff,   shf_in;
   logic                   ackc_ff,  ackc_in;
   logic                   scl_ff,   scl_in;
   logic                   sda_ff,   sda_in;
   logic                   drv_ff,   drv_in;
   logic                   nack_ff,  nack_in;
   logic [7:0]             rbyte_ff, rbyte_in;
   logic                   done_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   req_fire;
   logic [PeriodWidth-1:0] period_load;
   logic [PeriodWidth-1:0] dly_dec;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign period_load = (period_ff == '0) ? PeriodWidth'(1) : period_ff;
   assign dly_dec     = (dly_ff != '0) ? dly_ff - PeriodWidth'(1) : '0;

   always_comb begin
      op_in    = op_ff;
      step_in  = step_ff;
      bit_in   = bit_ff;
      dly_in   = dly_ff;
      shf_in   = shf_ff;
      ackc_in  = ackc_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      drv_in   = drv_ff;
      nack_in  = nack_ff;
      rbyte_in = rbyte_ff;
      done_in  = 1'b0;

      if (op_ff == OP_IDLE) begin
         // take a command only when idle; unknown codes are plain ticks
         if (req_data.command inside {OP_START, OP_STOP, OP_WRITE, OP_READ}) begin
            op_in   = req_data.command;
            bit_in  = '0;
            step_in = PH0;
            dly_in  = period_load;
            case (req_data.command)
               OP_START: begin
                  scl_in = 1'b1;
                  sda_in = 1'b1;
                  drv_in = 1'b1;
               end
               OP_STOP: begin
                  scl_in = 1'b0;
                  sda_in = 1'b0;
                  drv_in = 1'b1;
               end
               OP_WRITE: begin
                  shf_in = req_data.data_byte;
                  sda_in = req_data.data_byte[7];
                  drv_in = 1'b1;
               end
               default: begin
                  shf_in  = '0;
                  ackc_in = req_data.send_ack;
                  scl_in  = 1'b0;
               end
            endcase
         end
      end else begin
         dly_in = dly_dec;
         if (dly_dec == '0) begin
            // phase over: run its end action and load the next phase
            dly_in = period_load;
            case (op_ff)
               OP_START: begin
                  case (step_ff)
                     PH0: begin sda_in = 1'b0; step_in = PH1; end
                     PH1: begin scl_in = 1'b0; step_in = PH2; end
                     default: begin
                        op_in = OP_IDLE; step_in = PH0; bit_in = '0; dly_in = '0;
                        done_in = 1'b1;
                     end
                  endcase
               end
               OP_STOP: begin
                  case (step_ff)
                     PH0: begin scl_in = 1'b1; step_in = PH1; end
                     PH1: begin sda_in = 1'b1; step_in = PH2; end
                     default: begin
                        op_in = OP_IDLE; step_in = PH0; bit_in = '0; dly_in = '0;
                        done_in = 1'b1;
                     end
                  endcase
               end
               OP_WRITE: begin
                  case (step_ff)
                     PH0: begin scl_in = 1'b1; step_in = PH1; end
                     PH1: begin
                        scl_in = 1'b0;
                        if (bit_ff < BIT_LAST) begin
                           bit_in  = bit_ff + 4'd1;
                           shf_in  = {shf_ff[6:0], 1'b0};
                           sda_in  = shf_ff[6];
                           step_in = PH0;
                        end else begin
                           drv_in  = 1'b0;
                           step_in = PH2;
                        end
                     end
                     PH2: begin scl_in = 1'b1; step_in = PH3; end
                     PH3: begin
                        nack_in = req_data.sda_in;
                        drv_in  = 1'b1;
                        scl_in  = 1'b0;
                        if (req_data.sda_in) begin
                           op_in = OP_IDLE; step_in = PH0; bit_in = '0; dly_in = '0;
                           done_in = 1'b1;
                        end else begin
                           step_in = PH4;
                        end
                     end
                     default: begin
                        op_in = OP_IDLE; step_in = PH0; bit_in = '0; dly_in = '0;
                        done_in = 1'b1;
                     end
                  endcase
               end
               OP_READ: begin
                  case (step_ff)
                     PH0: begin sda_in = 1'b1; drv_in = 1'b0; step_in = PH1; end
                     PH1: begin scl_in = 1'b0; step_in = PH2; end
                     PH2: begin scl_in = 1'b1; step_in = PH3; end
                     PH3: begin
                        shf_in = {shf_ff[6:0], req_data.sda_in};
                        if (bit_ff < BIT_LAST) begin
                           step_in = PH4;
                        end else begin
                           bit_in  = BIT_ACK_WAIT;
                           drv_in  = 1'b1;
                           scl_in  = 1'b0;
                           step_in = PH5;
                        end
                     end
                     PH4: begin
                        bit_in  = bit_ff + 4'd1;
                        scl_in  = 1'b0;
                        step_in = PH2;
                     end
                     PH5: begin
                        // hold SCL low for a second phase before the ack bit
                        if (bit_ff == BIT_ACK_WAIT) begin
                           bit_in  = BIT_ACK_SEND;
                           step_in = PH5;
                        end else begin
                           sda_in  = !ackc_ff;
                           scl_in  = 1'b1;
                           step_in = PH6;
                        end
                     end
                     PH6: begin scl_in = 1'b0; step_in = PH7; end
                     default: begin
                        rbyte_in = shf_ff;
                        op_in = OP_IDLE; step_in = PH0; bit_in = '0; dly_in = '0;
                        done_in = 1'b1;
                     end
                  endcase
               end
               default: begin
                  op_in = OP_IDLE; step_in = PH0; bit_in = '0; dly_in = '0;
                  done_in = 1'b1;
               end
            endcase
         end
      end

      rsp_in.scl_level = scl_in;
      rsp_in.sda_level = sda_in;
      rsp_in.sda_drive = drv_in;
      rsp_in.busy_res  = (op_in != OP_IDLE);
      rsp_in.done_res  = done_in;
      rsp_in.read_data = rbyte_in;
      rsp_in.ack_error = nack_in;
   end

   always_comb begin
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= PERIOD_RESET;
         op_ff        <= OP_IDLE;
         step_ff      <= PH0;
         bit_ff       <= '0;
         dly_ff       <= '0;
         shf_ff       <= '0;
         ackc_ff      <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         drv_ff       <= 1'b1;
         nack_ff      <= 1'b0;
         rbyte_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            period_ff <= csr_data;
         end
         if (req_fire) begin
            op_ff    <= op_in;
            step_ff  <= step_in;
            bit_ff   <= bit_in;
            dly_ff   <= dly_in;
            shf_ff   <= shf_in;
            ackc_ff  <= ackc_in;
            scl_ff   <= scl_in;
            sda_ff   <= sda_in;
            drv_ff   <= drv_in;
            nack_ff  <= nack_in;
            rbyte_ff <= rbyte_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.done_res |-> !rsp_ff.busy_res)
      else $error("done reported while still busy");

   a_busy_has_delay: assert property (@(posedge clock) disable iff (reset)
      op_ff != OP_IDLE |-> dly_ff != '0)
      else $error("operation in progress with empty phase counter");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_ff <= BIT_ACK_SEND)
      else $error("bit counter out of range");

   a_state_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(op_ff) && $stable(dly_ff) && $stable(step_ff))
      else $error("bus state moved without an accepted item");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/i2c_master_byte_engine_tb.sv
// Self-checking bench for i2c_master_byte_engine: a directed table, then random
// bus sequences, each result checked against the table or a bus model in this file.
// Depends on i2cm_pkg for the payload types and command codes.

module i2c_master_byte_engine_tb;
   import i2cm_pkg::*;

   // command codes the engine must treat as a plain tick
   localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
   localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;

   typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [15:0] period;
      req_type    item;
      logic       drain;   // tick until idle afterwards, holding sda_in
      logic       typed;   // compare against want instead of the bus model
      rsp_type    want;
   } script_row_type;

   localparam rsp_type RESET_LINES = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
   localparam rsp_type NO_CHECK    = '0;
   localparam req_type IDLE_TICK   = '0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   logic        steady = 1'b0;
   int          fail_count = 0;
   rsp_type     pending_rsp_q [$];
   req_type     bus_plan_q [$];
   logic [15:0] random_periods [8] = '{16'd1, 16'd0, 16'd2, 16'd1, 16'd3, 16'd1, 16'd5, 16'd1};
   script_row_type directed_script [19];

   // bus model state
   logic [15:0] bus_period = PeriodReset;
   logic [2:0]  bus_op = OP_IDLE;
   logic [2:0]  bus_phase = PH0;
   logic [3:0]  bus_bit = '0;
   logic [15:0] bus_delay = '0;
   logic [7:0]  bus_shift = '0;
   logic        bus_ack_choice = 1'b0;
   logic        bus_scl = 1'b1;
   logic        bus_sda = 1'b1;
   logic        bus_drive = 1'b1;
   logic        bus_nack = 1'b0;
   logic [7:0]  bus_rd_byte = '0;
   logic        bus_done = 1'b0;

   i2c_master_byte_engine u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   function automatic logic take_break();
      return !steady && ($urandom_range(99) < 25);
   endfunction

   always @(negedge clock) begin
      rsp_ready <= !take_break();
   end

   function automatic void hold_phase(input logic [2:0] phase);
      bus_phase = phase;
      bus_delay = (bus_period == 16'd0) ? 16'd1 : bus_period;
   endfunction

   function automatic void close_op();
      bus_op = OP_IDLE;
      bus_phase = PH0;
      bus_bit = '0;
      bus_delay = '0;
      bus_done = 1'b1;
   endfunction

   // Advance the bus model by one tick and return the levels it drives.
   function automatic rsp_type step_bus(input req_type r);
      bus_done = 1'b0;
      if (bus_op == OP_IDLE) begin
         if (r.command >= OP_START && r.command <= OP_READ) begin
            bus_op = r.command;
            bus_bit = '0;
            case (r.command)
               OP_START: begin
                  bus_scl = 1'b1;
                  bus_sda = 1'b1;
                  bus_drive = 1'b1;
               end
               OP_STOP: begin
                  bus_scl = 1'b0;
                  bus_sda = 1'b0;
                  bus_drive = 1'b1;
               end
               OP_WRITE: begin
                  bus_shift = r.data_byte;
                  bus_sda = r.data_byte[7];
                  bus_drive = 1'b1;
               end
               default: begin
                  bus_shift = '0;
                  bus_ack_choice = r.send_ack;
                  bus_scl = 1'b0;
               end
            endcase
            hold_phase(PH0);
         end
      end else begin
         if (bus_delay != 16'd0) bus_delay--;
         if (bus_delay == 16'd0) begin
            case (bus_op)
               OP_START: begin
                  if (bus_phase == PH0) begin
                     bus_sda = 1'b0;
                     hold_phase(PH1);
                  end else if (bus_phase == PH1) begin
                     bus_scl = 1'b0;
                     hold_phase(PH2);
                  end else close_op();
               end
               OP_STOP: begin
                  if (bus_phase == PH0) begin
                     bus_scl = 1'b1;
                     hold_phase(PH1);
                  end else if (bus_phase == PH1) begin
                     bus_sda = 1'b1;
                     hold_phase(PH2);
                  end else close_op();
               end
               OP_WRITE: begin
                  case (bus_phase)
                     PH0: begin
                        bus_scl = 1'b1;
                        hold_phase(PH1);
                     end
                     PH1: begin
                        bus_scl = 1'b0;
                        if (bus_bit < BIT_LAST) begin
                           bus_bit++;
                           bus_shift = bus_shift << 1;
                           bus_sda = bus_shift[7];
                           hold_phase(PH0);
                        end else begin
                           // release SDA for the slave's acknowledge
                           bus_drive = 1'b0;
                           hold_phase(PH2);
                        end
                     end
                     PH2: begin
                        bus_scl = 1'b1;
                        hold_phase(PH3);
                     end
                     PH3: begin
                        bus_nack = r.sda_in;
                        bus_drive = 1'b1;
                        bus_scl = 1'b0;
                        if (bus_nack) close_op();
                        else hold_phase(PH4);
                     end
                     default: close_op();
                  endcase
               end
               OP_READ: begin
                  case (bus_phase)
                     PH0: begin
                        bus_sda = 1'b1;
                        bus_drive = 1'b0;
                        hold_phase(PH1);
                     end
                     PH1: begin
                        bus_scl = 1'b0;
                        hold_phase(PH2);
                     end
                     PH2: begin
                        bus_scl = 1'b1;
                        hold_phase(PH3);
                     end
                     PH3: begin
                        bus_shift = {bus_shift[6:0], r.sda_in};
                        if (bus_bit < BIT_LAST) hold_phase(PH4);
                        else begin
                           bus_bit = BIT_ACK_WAIT;
                           bus_drive = 1'b1;
                           bus_scl = 1'b0;
                           hold_phase(PH5);
                        end
                     end
                     PH4: begin
                        bus_bit++;
                        bus_scl = 1'b0;
                        hold_phase(PH2);
                     end
                     PH5: begin
                        // low clock is held for two phases before the ack bit
                        if (bus_bit == BIT_ACK_WAIT) begin
                           bus_bit = BIT_ACK_SEND;
                           hold_phase(PH5);
                        end else begin
                           bus_sda = !bus_ack_choice;
                           bus_scl = 1'b1;
                           hold_phase(PH6);
                        end
                     end
                     PH6: begin
                        bus_scl = 1'b0;
                        hold_phase(PH7);
                     end
                     default: begin
                        bus_rd_byte = bus_shift;
                        close_op();
                     end
                  endcase
               end
               default: close_op();
            endcase
         end
      end
      return '{bus_scl, bus_sda, bus_drive, bus_op != OP_IDLE, bus_done, bus_rd_byte,
               bus_nack};
   endfunction

   // Mostly whole start / data / stop sequences, with stray commands mixed in.
   function automatic req_type pick_item();
      req_type r;
      req_type op_item;
      int      count;
      r.command = OP_IDLE;
      r.data_byte = 8'($urandom);
      r.send_ack = 1'($urandom);
      r.sda_in = 1'($urandom);
      if (bus_op != OP_IDLE) begin
         if ($urandom_range(9) == 0) r.command = 3'($urandom_range(7));
      end else if ($urandom_range(3) != 0) begin
         if (bus_plan_q.size() == 0) begin
            if ($urandom_range(9) < 8) begin
               op_item = '0;
               op_item.command = OP_START;
               bus_plan_q.push_back(op_item);
               count = $urandom_range(3, 1);
               repeat (count) begin
                  op_item.command = $urandom_range(1) ? OP_WRITE : OP_READ;
                  op_item.data_byte = 8'($urandom);
                  op_item.send_ack = 1'($urandom);
                  bus_plan_q.push_back(op_item);
               end
               op_item.command = OP_STOP;
               bus_plan_q.push_back(op_item);
            end else r.command = 3'($urandom_range(7));
         end
         if (bus_plan_q.size() != 0) begin
            op_item = bus_plan_q.pop_front();
            r.command = op_item.command;
            r.data_byte = op_item.data_byte;
            r.send_ack = op_item.send_ack;
         end
      end
      return r;
   endfunction

   task automatic send_item(input req_type item, input logic typed, input rsp_type want);
      rsp_type predicted;
      @(negedge clock);
      while (take_break()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      predicted = step_bus(item);
      pending_rsp_q.push_back(typed ? want : predicted);
   endtask

   task automatic write_period(input logic [15:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      bus_period = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic log_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("mismatch: %s", msg);
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (pending_rsp_q.size() == 0) begin
         log_failure($sformatf("result %h with nothing pending", got));
      end else begin
         want = pending_rsp_q.pop_front();
         if (got.scl_level !== want.scl_level)
            log_failure($sformatf("scl_level exp %0h got %0h", want.scl_level, got.scl_level));
         if (got.sda_level !== want.sda_level)
            log_failure($sformatf("sda_level exp %0h got %0h", want.sda_level, got.sda_level));
         if (got.sda_drive !== want.sda_drive)
            log_failure($sformatf("sda_drive exp %0h got %0h", want.sda_drive, got.sda_drive));
         if (got.busy_res !== want.busy_res)
            log_failure($sformatf("busy_res exp %0h got %0h", want.busy_res, got.busy_res));
         if (got.done_res !== want.done_res)
            log_failure($sformatf("done_res exp %0h got %0h", want.done_res, got.done_res));
         if (got.read_data !== want.read_data)
            log_failure($sformatf("read_data exp %0h got %0h", want.read_data, got.read_data));
         if (got.ack_error !== want.ack_error)
            log_failure($sformatf("ack_error exp %0h got %0h", want.ack_error, got.ack_error));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_result(rsp_data);
   end

   initial begin
      #6000000;
      $display("status: fail");
      $finish;
   end

   initial begin
      script_row_type row;
      req_type     tick;

      directed_script = '{
         '{ROW_ITEM, 16'd0, '{OP_IDLE, 8'h00, 1'b0, 1'b0}, 1'b0, 1'b1, RESET_LINES},
         '{ROW_ITEM, 16'd0, '{CMD_RSVD_LAST, 8'hFF, 1'b1, 1'b1}, 1'b0, 1'b1, RESET_LINES},
         '{ROW_ITEM, 16'd0, '{CMD_RSVD_FIRST, 8'h00, 1'b0, 1'b0}, 1'b0, 1'b1, RESET_LINES},
         // write with no start before it: SCL stays high, the slave never acks
         '{ROW_ITEM, 16'd0, '{OP_WRITE, 8'h80, 1'b0, 1'b1}, 1'b1, 1'b1,
           '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
         // zero period acts as one tick per phase
         '{ROW_CFG, 16'd0, IDLE_TICK, 1'b0, 1'b0, NO_CHECK},
         '{ROW_ITEM, 16'd0, '{OP_START, 8'h00, 1'b0, 1'b0}, 1'b0, 1'b1,
           '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1}},
         '{ROW_ITEM, 16'd0, IDLE_TICK, 1'b0, 1'b0, NO_CHECK},
         '{ROW_ITEM, 16'd0, IDLE_TICK, 1'b0, 1'b0, NO_CHECK},
         // stop lands on the tick the start finishes: dropped
         '{ROW_ITEM, 16'd0, '{OP_STOP, 8'h00, 1'b0, 1'b0}, 1'b0, 1'b1,
           '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1}},
         '{ROW_ITEM, 16'd0, '{OP_STOP, 8'h00, 1'b0, 1'b0}, 1'b0, 1'b1,
           '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1}},
         '{ROW_ITEM, 16'd0, '{OP_WRITE, 8'h5A, 1'b0, 1'b0}, 1'b1, 1'b0, NO_CHECK},
         '{ROW_ITEM, 16'd0, '{OP_START, 8'h00, 1'b0, 1'b0}, 1'b1, 1'b0, NO_CHECK},
         '{ROW_ITEM, 16'd0, '{OP_WRITE, 8'hFF, 1'b0, 1'b0}, 1'b1, 1'b0, NO_CHECK},
         '{ROW_ITEM, 16'd0, '{OP_WRITE, 8'h00, 1'b0, 1'b1}, 1'b1, 1'b0, NO_CHECK},
         '{ROW_ITEM, 16'd0, '{OP_READ, 8'h00, 1'b1, 1'b1}, 1'b1, 1'b0, NO_CHECK},
         '{ROW_ITEM, 16'd0, '{OP_READ, 8'hFF, 1'b0, 1'b0}, 1'b1, 1'b0, NO_CHECK},
         '{ROW_ITEM, 16'd0, '{OP_STOP, 8'h00, 1'b0, 1'b0}, 1'b1, 1'b0, NO_CHECK},
         '{ROW_CFG, 16'd7, IDLE_TICK, 1'b0, 1'b0, NO_CHECK},
         '{ROW_ITEM, 16'd0, '{OP_START, 8'h00, 1'b0, 1'b0}, 1'b1, 1'b0, NO_CHECK}
      };

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_script[idx]) begin
         row = directed_script[idx];
         if (row.kind == ROW_CFG) begin
            write_period(row.period);
         end else begin
            send_item(row.item, row.typed, row.want);
            tick = row.item;
            tick.command = OP_IDLE;
            while (row.drain && bus_op != OP_IDLE) send_item(tick, 1'b0, NO_CHECK);
         end
      end

      for (int ph = 0; ph < 8; ph++) begin
         write_period(random_periods[ph]);
         steady = (ph == 3);
         repeat (120) send_item(pick_item(), 1'b0, NO_CHECK);
         // finish the operation in flight before the period changes
         while (bus_op != OP_IDLE) send_item(pick_item(), 1'b0, NO_CHECK);
      end
      steady = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_rsp_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
